// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: quaternion vector rotation constants and types
// Fixed-point formats, datapath widths and pipeline depth shared by the block.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned SHIFT     = 2 * FRAC_BITS;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 18;

  // first product terms and the exact intermediate quaternion
  localparam int unsigned M1_W = 2 * IN_W;
  localparam int unsigned P_W  = M1_W + 1;

  // split of p for the second product: signed high part, unsigned low part
  localparam int unsigned LO_W  = P_W - IN_W;
  localparam int unsigned MH_W  = 2 * IN_W;
  localparam int unsigned ML_W  = LO_W + 1 + IN_W;
  localparam int unsigned PR_W  = P_W + IN_W + 1;
  localparam int unsigned R_W   = PR_W + 3;
  localparam int unsigned SH_W  = R_W - SHIFT;

  localparam int unsigned NSTAGE = 7;
  localparam int unsigned NTERM  = 12;

  localparam logic signed [R_W-1:0] ROUND_ADD =
    {{(R_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [IN_W-1:0] comp_t;
  typedef logic signed [P_W-1:0]  pcomp_t;
  typedef logic signed [PR_W-1:0] term_t;
  typedef logic signed [R_W-1:0]  acc_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

endpackage

// ===== src/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: q v conj(q) / conj(q) v q rotation pipeline
// Two Hamilton products on a pure quaternion; exact first product, second
// product rounded half up by 2^(2*FRAC_BITS) and saturated to 18 bits.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transaction
//  --------+-------------------------------------------+----------------------
//  in      | in_valid_i / in_ready_o, quat_*_i, vec_*_i | quaternion + vector
//  out     | out_valid_o / out_ready_i, rot_*_o, clipped_o | rotated vector
//  cfg     | cfg_we_i, cfg_wdata_i                      | rotate_mode write
//
//  Seven register stages, one transaction per cycle while the output is not stalled.
//  Stages: first products, p, split second products, recombine, pair sums,
//  round, saturate into the output register.
//  Each stage holds while the next is full and stalled; bubbles are absorbed.
//  Reset clears the valid bits and rotate_mode; datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [qvr_pkg::IN_W-1:0]  quat_x_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  quat_y_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  quat_z_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  quat_w_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  vec_x_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  vec_y_i,
  input  logic signed [qvr_pkg::IN_W-1:0]  vec_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_x_o,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_y_o,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_z_o,
  output logic                             clipped_o
);

  logic                         mode_q;
  logic [qvr_pkg::NSTAGE-1:0]   valid_q;
  logic [qvr_pkg::NSTAGE:0]     en;

  // stage 1
  logic signed [qvr_pkg::M1_W-1:0] m_xx_q, m_yy_q, m_zz_q;
  logic signed [qvr_pkg::M1_W-1:0] m_wx_q, m_wy_q, m_wz_q;
  logic signed [qvr_pkg::M1_W-1:0] m_yvz_q, m_zvy_q, m_zvx_q, m_xvz_q, m_xvy_q, m_yvx_q;
  qvr_pkg::quat_t                  q1_q;
  logic                            md1_q;

  // stage 2
  qvr_pkg::pcomp_t pw_q, px_q, py_q, pz_q;
  qvr_pkg::quat_t  q2_q;
  logic            md2_q;

  // stage 3
  qvr_pkg::pcomp_t               tp   [qvr_pkg::NTERM];
  qvr_pkg::comp_t                tq   [qvr_pkg::NTERM];
  logic signed [qvr_pkg::MH_W-1:0] mh_q [qvr_pkg::NTERM];
  logic signed [qvr_pkg::ML_W-1:0] ml_q [qvr_pkg::NTERM];
  logic                            md3_q;

  // stage 4
  qvr_pkg::term_t full_q [qvr_pkg::NTERM];
  logic           md4_q;

  // stage 5
  qvr_pkg::acc_t  a_q [3];
  qvr_pkg::acc_t  b_q [3];
  logic           md5_q;

  // stage 6
  qvr_pkg::acc_t  r_q [3];

  // stage 7
  logic signed [qvr_pkg::OUT_W-1:0] rot_q [3];
  logic                             clip_q;

  logic signed [qvr_pkg::OUT_W-1:0] sat_d [3];
  logic                             clip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    en[qvr_pkg::NSTAGE] = out_ready_i;
    for (int i = qvr_pkg::NSTAGE - 1; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < qvr_pkg::NSTAGE; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // stage 1: first-product terms
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_xx_q  <= qvr_pkg::M1_W'(quat_x_i) * qvr_pkg::M1_W'(vec_x_i);
      m_yy_q  <= qvr_pkg::M1_W'(quat_y_i) * qvr_pkg::M1_W'(vec_y_i);
      m_zz_q  <= qvr_pkg::M1_W'(quat_z_i) * qvr_pkg::M1_W'(vec_z_i);
      m_wx_q  <= qvr_pkg::M1_W'(quat_w_i) * qvr_pkg::M1_W'(vec_x_i);
      m_wy_q  <= qvr_pkg::M1_W'(quat_w_i) * qvr_pkg::M1_W'(vec_y_i);
      m_wz_q  <= qvr_pkg::M1_W'(quat_w_i) * qvr_pkg::M1_W'(vec_z_i);
      m_yvz_q <= qvr_pkg::M1_W'(quat_y_i) * qvr_pkg::M1_W'(vec_z_i);
      m_zvy_q <= qvr_pkg::M1_W'(quat_z_i) * qvr_pkg::M1_W'(vec_y_i);
      m_zvx_q <= qvr_pkg::M1_W'(quat_z_i) * qvr_pkg::M1_W'(vec_x_i);
      m_xvz_q <= qvr_pkg::M1_W'(quat_x_i) * qvr_pkg::M1_W'(vec_z_i);
      m_xvy_q <= qvr_pkg::M1_W'(quat_x_i) * qvr_pkg::M1_W'(vec_y_i);
      m_yvx_q <= qvr_pkg::M1_W'(quat_y_i) * qvr_pkg::M1_W'(vec_x_i);
      q1_q    <= '{x: quat_x_i, y: quat_y_i, z: quat_z_i, w: quat_w_i};
      md1_q   <= mode_q;
    end
  end

  // stage 2: p = a * (v, 0), conj sign folded into the cross terms
  qvr_pkg::pcomp_t dot_d, crx_d, cry_d, crz_d;

  always_comb begin
    dot_d = qvr_pkg::P_W'(m_xx_q) + qvr_pkg::P_W'(m_yy_q) + qvr_pkg::P_W'(m_zz_q);
    crx_d = qvr_pkg::P_W'(m_yvz_q) - qvr_pkg::P_W'(m_zvy_q);
    cry_d = qvr_pkg::P_W'(m_zvx_q) - qvr_pkg::P_W'(m_xvz_q);
    crz_d = qvr_pkg::P_W'(m_xvy_q) - qvr_pkg::P_W'(m_yvx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pw_q  <= md1_q ? dot_d : -dot_d;
      px_q  <= qvr_pkg::P_W'(m_wx_q) + (md1_q ? -crx_d : crx_d);
      py_q  <= qvr_pkg::P_W'(m_wy_q) + (md1_q ? -cry_d : cry_d);
      pz_q  <= qvr_pkg::P_W'(m_wz_q) + (md1_q ? -crz_d : crz_d);
      q2_q  <= q1_q;
      md2_q <= md1_q;
    end
  end

  // stage 3: second-product terms, per component [A1, A2, B1, B2]
  always_comb begin
    tp[0]  = px_q;  tq[0]  = q2_q.w;
    tp[1]  = pw_q;  tq[1]  = q2_q.x;
    tp[2]  = py_q;  tq[2]  = q2_q.z;
    tp[3]  = pz_q;  tq[3]  = q2_q.y;
    tp[4]  = py_q;  tq[4]  = q2_q.w;
    tp[5]  = pw_q;  tq[5]  = q2_q.y;
    tp[6]  = px_q;  tq[6]  = q2_q.z;
    tp[7]  = pz_q;  tq[7]  = q2_q.x;
    tp[8]  = pz_q;  tq[8]  = q2_q.w;
    tp[9]  = pw_q;  tq[9]  = q2_q.z;
    tp[10] = py_q;  tq[10] = q2_q.x;
    tp[11] = px_q;  tq[11] = q2_q.y;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < qvr_pkg::NTERM; k++) begin
        mh_q[k] <= qvr_pkg::MH_W'($signed(tp[k][qvr_pkg::P_W-1:qvr_pkg::LO_W])) *
                   qvr_pkg::MH_W'(tq[k]);
        ml_q[k] <= qvr_pkg::ML_W'($signed({1'b0, tp[k][qvr_pkg::LO_W-1:0]})) *
                   qvr_pkg::ML_W'(tq[k]);
      end
      md3_q <= md2_q;
    end
  end

  // stage 4: recombine split products
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < qvr_pkg::NTERM; k++) begin
        full_q[k] <= (qvr_pkg::PR_W'(mh_q[k]) <<< qvr_pkg::LO_W) + qvr_pkg::PR_W'(ml_q[k]);
      end
      md4_q <= md3_q;
    end
  end

  // stage 5: pair sums
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        a_q[c] <= qvr_pkg::R_W'(full_q[4*c]) +
                  (md4_q ? qvr_pkg::R_W'(full_q[4*c+1]) : -qvr_pkg::R_W'(full_q[4*c+1]));
        b_q[c] <= qvr_pkg::R_W'(full_q[4*c+2]) - qvr_pkg::R_W'(full_q[4*c+3]);
      end
      md5_q <= md4_q;
    end
  end

  // stage 6: final sum with rounding offset; x takes the opposite cross sign
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      r_q[0] <= a_q[0] + (md5_q ? b_q[0] : -b_q[0]) + qvr_pkg::ROUND_ADD;
      r_q[1] <= a_q[1] + (md5_q ? -b_q[1] : b_q[1]) + qvr_pkg::ROUND_ADD;
      r_q[2] <= a_q[2] + (md5_q ? -b_q[2] : b_q[2]) + qvr_pkg::ROUND_ADD;
    end
  end

  // stage 7: floor shift and saturate
  always_comb begin
    logic signed [qvr_pkg::SH_W-1:0]       sh;
    logic [qvr_pkg::SH_W-qvr_pkg::OUT_W:0] top;
    clip_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sh  = r_q[c][qvr_pkg::R_W-1:qvr_pkg::SHIFT];
      top = sh[qvr_pkg::SH_W-1:qvr_pkg::OUT_W-1];
      if ((&top) || !(|top)) begin
        sat_d[c] = sh[qvr_pkg::OUT_W-1:0];
      end else begin
        sat_d[c] = sh[qvr_pkg::SH_W-1] ? qvr_pkg::OUT_MIN : qvr_pkg::OUT_MAX;
        clip_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        rot_q[c] <= sat_d[c];
      end
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = valid_q[qvr_pkg::NSTAGE-1];
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign clipped_o   = clip_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: quaternion_vector_rotate
// Drives quaternion/vector transactions through the rotation pipeline in both
// modes, predicts each rotated vector with 64-bit integer Hamilton products,
// and compares every result field against the oldest pending prediction, with
// both channels stalling at random in all phases but the last.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SCALE_SHIFT = 2 * 14;
  localparam longint ROT_MAX = 131071;
  localparam longint ROT_MIN = -131072;

  typedef struct packed {
    qvr_pkg::comp_t qx;
    qvr_pkg::comp_t qy;
    qvr_pkg::comp_t qz;
    qvr_pkg::comp_t qw;
    qvr_pkg::comp_t vx;
    qvr_pkg::comp_t vy;
    qvr_pkg::comp_t vz;
  } rotation_req_t;

  typedef struct packed {
    logic signed [qvr_pkg::OUT_W-1:0] x;
    logic signed [qvr_pkg::OUT_W-1:0] y;
    logic signed [qvr_pkg::OUT_W-1:0] z;
    logic                             clipped;
  } rotation_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
  } wide_quat_t;

  class rotation_board;
    rotation_t   expected_q[$];
    bit          active_mode;
    int unsigned errors;
    int unsigned checked;
    int unsigned saturated;

    function void set_mode(bit m);
      active_mode = m;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function wide_quat_t hamilton(wide_quat_t a, wide_quat_t b);
      wide_quat_t r;
      r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
      r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
      r.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
      r.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
      return r;
    endfunction

    // round half up, then clamp to 18 bits
    function longint settle(longint v, ref bit clip);
      longint r;
      r = (v + (64'sd1 <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
      if (r > ROT_MAX) begin
        r = ROT_MAX;
        clip = 1'b1;
      end else if (r < ROT_MIN) begin
        r = ROT_MIN;
        clip = 1'b1;
      end
      return r;
    endfunction

    function void note_input(rotation_req_t req);
      wide_quat_t q, qc, v, p, r;
      rotation_t  exp;
      bit         clip;
      clip = 1'b0;
      q.x  = longint'(req.qx);
      q.y  = longint'(req.qy);
      q.z  = longint'(req.qz);
      q.w  = longint'(req.qw);
      qc.x = -q.x;
      qc.y = -q.y;
      qc.z = -q.z;
      qc.w = q.w;
      v.x  = longint'(req.vx);
      v.y  = longint'(req.vy);
      v.z  = longint'(req.vz);
      v.w  = 64'sd0;
      if (active_mode) begin
        p = hamilton(qc, v);
        r = hamilton(p, q);
      end else begin
        p = hamilton(q, v);
        r = hamilton(p, qc);
      end
      exp.x       = qvr_pkg::OUT_W'(settle(r.x, clip));
      exp.y       = qvr_pkg::OUT_W'(settle(r.y, clip));
      exp.z       = qvr_pkg::OUT_W'(settle(r.z, clip));
      exp.clipped = clip;
      expected_q.push_back(exp);
    endfunction

    function void compare_field(string name, longint exp, longint got);
      if (exp != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp, got);
      end
    endfunction

    function void check_result(rotation_t got);
      rotation_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: got %0d %0d %0d clipped %0b", $time,
                 got.x, got.y, got.z, got.clipped);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.clipped === 1'b1) saturated++;
      if ($isunknown(got)) begin
        errors++;
        $display("%0t unknown bits in result: expected %0d %0d %0d %0b, got %h",
                 $time, exp.x, exp.y, exp.z, exp.clipped, got);
        return;
      end
      compare_field("rot_x", longint'(exp.x), longint'(got.x));
      compare_field("rot_y", longint'(exp.y), longint'(got.y));
      compare_field("rot_z", longint'(exp.z), longint'(got.z));
      compare_field("clipped", longint'(exp.clipped), longint'(got.clipped));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  qvr_pkg::comp_t quat_x_i = '0;
  qvr_pkg::comp_t quat_y_i = '0;
  qvr_pkg::comp_t quat_z_i = '0;
  qvr_pkg::comp_t quat_w_i = '0;
  qvr_pkg::comp_t vec_x_i = '0;
  qvr_pkg::comp_t vec_y_i = '0;
  qvr_pkg::comp_t vec_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [qvr_pkg::OUT_W-1:0] rot_x_o;
  logic signed [qvr_pkg::OUT_W-1:0] rot_y_o;
  logic signed [qvr_pkg::OUT_W-1:0] rot_z_o;
  logic clipped_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  rotation_board board;

  rotation_req_t corner_cases[12] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd100, -16'sd200, 16'sd300},
    '{16'sd1234, -16'sd5678, 16'sd9012, -16'sd3456, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd1000, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd8192, 16'sd2, 16'sd6, -16'sd2},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000},
    '{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
    '{16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sh7fff}
  };

  quaternion_vector_rotate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .quat_w_i    (quat_w_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .clipped_o   (clipped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_result('{rot_x_o, rot_y_o, rot_z_o, clipped_o});
      end
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic qvr_pkg::comp_t pick_component();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1, 2: return qvr_pkg::comp_t'($urandom_range(4095)) - 16'sd2048;
      3: return qvr_pkg::comp_t'($urandom_range(32767)) - 16'sd16384;
      default: return qvr_pkg::comp_t'($urandom);
    endcase
  endfunction

  task automatic send_rotation(rotation_req_t req);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_x_i   <= req.qx;
    quat_y_i   <= req.qy;
    quat_z_i   <= req.qz;
    quat_w_i   <= req.qw;
    vec_x_i    <= req.vx;
    vec_y_i    <= req.vy;
    vec_z_i    <= req.vz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(req);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_mode(m);
  endtask

  initial begin
    rotation_req_t req;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    src_idle_pct  <= 17;
    sink_idle_pct <= 47;
    foreach (corner_cases[i]) send_rotation(corner_cases[i]);
    wait_drained();
    write_mode(1'b1);
    foreach (corner_cases[i]) send_rotation(corner_cases[i]);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      write_mode(ph[0] == 1'b0 ? 1'b0 : 1'b1);
      src_idle_pct  <= (ph == 0) ? 17 : (ph == 1) ? 47 : 0;
      sink_idle_pct <= (ph == 0) ? 47 : (ph == 1) ? 17 : 0;
      for (int n = 0; n < 250; n++) begin
        if (n == 125) wait_drained();
        req = '{pick_component(), pick_component(), pick_component(), pick_component(),
                pick_component(), pick_component(), pick_component()};
        if ($urandom_range(19) == 0) begin
          req.vx = '0;
          req.vy = '0;
          req.vz = '0;
        end
        send_rotation(req);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("checked %0d rotations across both modes and three stall patterns", board.checked);
    $display("%0d results saturated, %0d mismatches", board.saturated, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d transactions outstanding", board.pending());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/qvr_pkg.sv
src/quaternion_vector_rotate.sv
tb/testbench.sv
